/* sv/assert_macros.svh */
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion on clk_i, disabled while rst_ni is low.
`define BTHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication form of the above.
`define BTHT_ASSERT_IMP(lbl, pre, post, msg) \
  `BTHT_ASSERT(lbl, (pre) |-> (post), msg)

`endif

/* sv/btht_pkg.sv */
// ----------------------------------------------------------------------------
// btht_pkg
// Shared constants of the rectangle table hit tester.
// ----------------------------------------------------------------------------
package btht_pkg;

  localparam int TableDepth = 64;
  localparam int CoordWidth = 16;
  localparam int IdWidth    = 16;

  localparam int ModeWidth  = 2;
  localparam int IndexWidth = 6;
  localparam int CountWidth = 7;
  localparam int ZWidth     = 16;
  localparam int FlagWidth  = 2;
  localparam int MapWidth   = 64;
  localparam int DepthWidth = 6;

  localparam logic [ModeWidth-1:0] ModeWrite = 2'd0;
  localparam logic [ModeWidth-1:0] ModePoint = 2'd1;
  localparam logic [ModeWidth-1:0] ModeDepth = 2'd2;

endpackage

/* sv/box_table_hit_test.sv */
// ----------------------------------------------------------------------------
// box_table_hit_test
// Rectangle table with point hit test and parent depth walk.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid_i / in_ready_o. A write request loads one
//   table slot and gives no result; mode 3 is taken and dropped.
//   Point and depth queries give one result on out_valid_o / out_ready_i.
//   The configuration channel (cfg_valid_i / cfg_ready_o) sets entry_count.
//   A point query reads one entry per cycle through the registered memory
//   port. A depth query searches the used table once per id on the parent
//   chain, at most entry_count + 1 searches, then loads the result.
//   One request is worked on at a time; in_ready_o is high while idle. The
//   output register lets a new request in while the last result waits; a
//   query that finishes while it is full holds until the receiver drains it.
//   Reset clears entry_count and control state; the table is undefined
//   until written and gets no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module box_table_hit_test #(
  parameter int TABLE_DEPTH = btht_pkg::TableDepth,
  parameter int COORD_WIDTH = btht_pkg::CoordWidth,
  parameter int ID_WIDTH    = btht_pkg::IdWidth
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [btht_pkg::CountWidth-1:0]    cfg_entry_count_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [btht_pkg::ModeWidth-1:0]     mode_i,
  input  logic [btht_pkg::IndexWidth-1:0]    index_i,
  input  logic signed [COORD_WIDTH-1:0]      box_x_i,
  input  logic signed [COORD_WIDTH-1:0]      box_y_i,
  input  logic signed [COORD_WIDTH-1:0]      box_w_i,
  input  logic signed [COORD_WIDTH-1:0]      box_h_i,
  input  logic signed [btht_pkg::ZWidth-1:0] box_z_i,
  input  logic [ID_WIDTH-1:0]                box_id_i,
  input  logic [ID_WIDTH-1:0]                parent_id_i,
  input  logic [btht_pkg::FlagWidth-1:0]     flags_i,
  input  logic signed [COORD_WIDTH-1:0]      point_x_i,
  input  logic signed [COORD_WIDTH-1:0]      point_y_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [ID_WIDTH-1:0]                hit_id_o,
  output logic [btht_pkg::MapWidth-1:0]      hit_bitmap_o,
  output logic [btht_pkg::CountWidth-1:0]    hit_count_o,
  output logic [btht_pkg::DepthWidth-1:0]    depth_o,
  output logic                               depth_found_o
);
  import btht_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = COORD_WIDTH;
  localparam int IW = ID_WIDTH;

  // Packed entry layout: x, y, w, h, z, id, parent, flags from bit 0 up.
  localparam int XO = 0;
  localparam int YO = XO + CW;
  localparam int WO = YO + CW;
  localparam int HO = WO + CW;
  localparam int ZO = HO + CW;
  localparam int IO = ZO + ZWidth;
  localparam int PO = IO + IW;
  localparam int FO = PO + IW;
  localparam int EW = FO + FlagWidth;

  localparam logic [CountWidth-1:0] DepthCount = CountWidth'(TABLE_DEPTH);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StScan = 3'd1;
  localparam logic [2:0] StLook = 3'd2;
  localparam logic [2:0] StFin  = 3'd3;

  logic [2:0]            state_q;
  logic [CountWidth-1:0] entry_count_q;
  logic [CountWidth-1:0] n_q;
  logic [CountWidth-1:0] iss_q;
  logic                  pend_q;
  logic [AW-1:0]         ev_q;
  logic signed [CW-1:0]  px_q, py_q;
  logic [IW-1:0]         target_q;
  logic [CountWidth-1:0] steps_q;
  logic                  first_q;

  // Result accumulators.
  logic [IW-1:0]            hit_q;
  logic signed [ZWidth-1:0] best_z_q;
  logic [MapWidth-1:0]      map_q;
  logic [CountWidth-1:0]    cnt_q;
  logic [DepthWidth-1:0]    dep_q;
  logic                     found_q;

  logic [EW-1:0] mem [TABLE_DEPTH];
  logic [EW-1:0] rd_q;

  logic accept, wr_en;
  assign in_ready_o  = (state_q == StIdle);
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;
  assign wr_en       = accept && (mode_i == ModeWrite) &&
                       (CountWidth'(index_i) < DepthCount);

  // Table memory: one write port at request time, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[index_i[AW-1:0]] <= {flags_i, parent_id_i, box_id_i, box_z_i,
                               box_h_i, box_w_i, box_y_i, box_x_i};
    end
    rd_q <= mem[iss_q[AW-1:0]];
  end

  // Fields of the entry read last cycle.
  logic signed [CW-1:0]     e_x, e_y, e_w, e_h;
  logic signed [ZWidth-1:0] e_z;
  logic [IW-1:0]            e_id, e_par;
  logic [FlagWidth-1:0]     e_fl;
  logic signed [CW:0]       x_end, y_end;
  logic                     contain, last;
  logic [CountWidth-1:0]    new_steps;
  logic [CountWidth-1:0]    n_new;
  logic                     restart;
  logic                     out_load;

  always_comb begin
    e_x   = rd_q[XO +: CW];
    e_y   = rd_q[YO +: CW];
    e_w   = rd_q[WO +: CW];
    e_h   = rd_q[HO +: CW];
    e_z   = rd_q[ZO +: ZWidth];
    e_id  = rd_q[IO +: IW];
    e_par = rd_q[PO +: IW];
    e_fl  = rd_q[FO +: FlagWidth];
    x_end = (CW+1)'(e_x) + (CW+1)'(e_w);
    y_end = (CW+1)'(e_y) + (CW+1)'(e_h);
    // Half-open containment; a negative size never contains.
    contain = !e_w[CW-1] && !e_h[CW-1] && (px_q >= e_x) && (py_q >= e_y) &&
              ((CW+1)'(px_q) < x_end) && ((CW+1)'(py_q) < y_end);
    last      = pend_q && (CountWidth'(ev_q) == n_q - CountWidth'(1));
    new_steps = first_q ? steps_q : steps_q + CountWidth'(1);
    n_new     = (entry_count_q > DepthCount) ? DepthCount : entry_count_q;
    // The walk found the id and goes on with its parent from slot 0.
    restart   = (state_q == StLook) && pend_q && (e_id == target_q) &&
                (e_par != '0) && (new_steps < n_q);
    out_load  = (state_q == StFin) && (!out_valid_o || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      entry_count_q <= cfg_entry_count_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      iss_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i && !out_load) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (accept) begin
            n_q      <= n_new;
            px_q     <= point_x_i;
            py_q     <= point_y_i;
            target_q <= box_id_i;
            steps_q  <= '0;
            first_q  <= 1'b1;
            hit_q    <= '0;
            best_z_q <= '0;
            map_q    <= '0;
            cnt_q    <= '0;
            dep_q    <= '0;
            found_q  <= 1'b0;
            iss_q    <= '0;
            pend_q   <= 1'b0;
            if (mode_i == ModePoint) begin
              state_q <= (n_new == '0) ? StFin : StScan;
            end else if (mode_i == ModeDepth) begin
              state_q <= (n_new == '0 || box_id_i == '0) ? StFin : StLook;
            end
          end
        end
        StScan, StLook: begin
          if (restart) begin
            // Drop the read in flight and search again from slot 0.
            iss_q  <= '0;
            pend_q <= 1'b0;
          end else if (iss_q < n_q) begin
            iss_q  <= iss_q + CountWidth'(1);
            pend_q <= 1'b1;
            ev_q   <= iss_q[AW-1:0];
          end else begin
            pend_q <= 1'b0;
          end
          if (state_q == StScan) begin
            if (pend_q && e_fl[0] && contain) begin
              map_q <= map_q | (MapWidth'(1) << ev_q);
              cnt_q <= cnt_q + CountWidth'(1);
              if (e_fl[1] && (hit_q == '0 || e_z > best_z_q ||
                              (e_z == best_z_q && e_id > hit_q))) begin
                hit_q    <= e_id;
                best_z_q <= e_z;
              end
            end
            if (last) begin
              state_q <= StFin;
            end
          end else if (pend_q && e_id == target_q) begin
            if (e_par == '0) begin
              dep_q   <= new_steps[DepthWidth-1:0];
              found_q <= 1'b1;
              state_q <= StFin;
            end else if (new_steps >= n_q) begin
              state_q <= StFin;
            end else begin
              // Look up the parent next.
              target_q <= e_par;
              steps_q  <= new_steps;
              first_q  <= 1'b0;
            end
          end else if (last) begin
            state_q <= StFin;
          end
        end
        StFin: begin
          pend_q <= 1'b0;
          if (out_load) begin
            out_valid_o   <= 1'b1;
            hit_id_o      <= hit_q;
            hit_bitmap_o  <= map_q;
            hit_count_o   <= cnt_q;
            depth_o       <= dep_q;
            depth_found_o <= found_q;
            state_q       <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  `BTHT_ASSERT_IMP(a_count_matches_map, out_valid_o, hit_count_o == 7'($countones(hit_bitmap_o)), "hit count disagrees with bitmap")
  `BTHT_ASSERT_IMP(a_depth_zero_on_fail, out_valid_o && !depth_found_o, depth_o == '0, "depth set on failed lookup")
  `BTHT_ASSERT_IMP(a_pend_only_in_scan, pend_q, state_q == StScan || state_q == StLook || state_q == StFin, "read pending outside a scan")
  `BTHT_ASSERT_IMP(a_result_from_fin, $rose(out_valid_o), $past(state_q) == StFin, "result raised outside finish")

endmodule

/* verif/tb_box_table_hit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_box_table_hit_test
// Self-checking bench for the rectangle table hit tester.
// ----------------------------------------------------------------------------
// The bench mirrors the table and entry_count in its own scoreboard model.
// Each accepted query request is turned into an expected result. Results are
// compared field by field, in order, as they leave the block.
//
// The run has four parts:
//   - two queries against an empty table;
//   - a fill of every slot;
//   - a short directed list covering the coordinate extremes, half-open
//     edges, negative sizes, z and id ties, and the depth failure cases;
//   - random phases at several entry_count settings, 0 and the clamp range
//     above 64 among them.
// Both sides insert random gaps, except during the fill and in some phases.
// ----------------------------------------------------------------------------
module tb_box_table_hit_test;
  import btht_pkg::*;

  localparam int  LimitCycles = 20000000;
  localparam int  IdPool      = 40;
  localparam byte ModeNone    = 8'd3;  // undefined mode, dropped by the block

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic [IdWidth-1:0]           ident_t;

  typedef struct {
    logic [ModeWidth-1:0]  mode;
    logic [IndexWidth-1:0] index;
    coord_t                bx, by, bw, bh;
    logic signed [ZWidth-1:0] bz;
    ident_t                id, parent;
    logic [FlagWidth-1:0]  flags;
    coord_t                px, py;
  } request_t;

  typedef struct {
    ident_t                 hit_id;
    logic [MapWidth-1:0]    bitmap;
    logic [CountWidth-1:0]  count;
    logic [DepthWidth-1:0]  depth;
    logic                   found;
  } answer_t;

  // A directed row, with a typed-in answer where one is obvious.
  typedef struct {
    request_t req;
    bit       typed;
    answer_t  ans;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CountWidth-1:0] cfg_count = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  request_t              drv = '{default: '0};
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  ident_t                hit_id;
  logic [MapWidth-1:0]   hit_bitmap;
  logic [CountWidth-1:0] hit_count;
  logic [DepthWidth-1:0] depth;
  logic                  depth_found;

  // Scoreboard copy of the block state.
  logic [CountWidth-1:0]    entry_count_q = '0;
  coord_t                   box_x_q [TableDepth];
  coord_t                   box_y_q [TableDepth];
  coord_t                   box_w_q [TableDepth];
  coord_t                   box_h_q [TableDepth];
  logic signed [ZWidth-1:0] box_z_q [TableDepth];
  ident_t                   box_id_q [TableDepth];
  ident_t                   box_par_q [TableDepth];
  logic [FlagWidth-1:0]     box_flags_q [TableDepth];

  answer_t pending_answers[$];
  int      errors = 0;
  int      results_seen = 0;
  int      requests_sent = 0;
  int      cycles = 0;
  bit      calm = 1'b0;  // when set, neither side inserts gaps

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  box_table_hit_test i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_entry_count_i(cfg_count),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .mode_i           (drv.mode),
    .index_i          (drv.index),
    .box_x_i          (drv.bx),
    .box_y_i          (drv.by),
    .box_w_i          (drv.bw),
    .box_h_i          (drv.bh),
    .box_z_i          (drv.bz),
    .box_id_i         (drv.id),
    .parent_id_i      (drv.parent),
    .flags_i          (drv.flags),
    .point_x_i        (drv.px),
    .point_y_i        (drv.py),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .hit_id_o         (hit_id),
    .hit_bitmap_o     (hit_bitmap),
    .hit_count_o      (hit_count),
    .depth_o          (depth),
    .depth_found_o    (depth_found)
  );

  // Counts above the table size are clamped by the block.
  function automatic int used_entries();
    return (entry_count_q > TableDepth) ? TableDepth : int'(entry_count_q);
  endfunction

  // Slot holding the id among the used entries, or -1.
  function automatic int find_slot(ident_t id, int n);
    if (id == '0) return -1;
    for (int i = 0; i < n; i++) begin
      if (box_id_q[i] == id) return i;
    end
    return -1;
  endfunction

  // Point hit test: half-open containment, topmost visible and enabled entry.
  function automatic answer_t point_hits(coord_t px, coord_t py);
    answer_t a;
    logic signed [ZWidth-1:0] best_z;
    int n;
    a = '{default: '0};
    best_z = '0;
    n = used_entries();
    for (int i = 0; i < n; i++) begin
      if (!box_flags_q[i][0]) continue;
      if (box_w_q[i] < 0 || box_h_q[i] < 0) continue;
      if (!(int'(px) >= int'(box_x_q[i]) && int'(py) >= int'(box_y_q[i]) &&
            int'(px) < int'(box_x_q[i]) + int'(box_w_q[i]) &&
            int'(py) < int'(box_y_q[i]) + int'(box_h_q[i]))) continue;
      a.bitmap[i] = 1'b1;
      a.count++;
      if (box_flags_q[i] == 2'b11) begin
        if (a.hit_id == '0 || box_z_q[i] > best_z ||
            (box_z_q[i] == best_z && box_id_q[i] > a.hit_id)) begin
          best_z   = box_z_q[i];
          a.hit_id = box_id_q[i];
        end
      end
    end
    return a;
  endfunction

  // Parent walk: a chain longer than the used entries counts as a cycle.
  function automatic answer_t parent_depth(ident_t id);
    answer_t a;
    int n, slot, steps;
    ident_t up;
    a = '{default: '0};
    n = used_entries();
    slot = find_slot(id, n);
    if (slot < 0) return a;
    up = box_par_q[slot];
    steps = 0;
    while (up != '0) begin
      if (steps >= n) return a;
      slot = find_slot(up, n);
      if (slot < 0) return a;
      up = box_par_q[slot];
      steps++;
    end
    a.depth = steps[DepthWidth-1:0];
    a.found = 1'b1;
    return a;
  endfunction

  // Updates the table copy for an accepted request and returns the expected
  // result; has_result is cleared for writes and the undefined mode.
  function automatic answer_t apply_request(request_t r, output bit has_result);
    has_result = 1'b0;
    case (r.mode)
      ModeWrite: begin
        box_x_q[r.index]     = r.bx;
        box_y_q[r.index]     = r.by;
        box_w_q[r.index]     = r.bw;
        box_h_q[r.index]     = r.bh;
        box_z_q[r.index]     = r.bz;
        box_id_q[r.index]    = r.id;
        box_par_q[r.index]   = r.parent;
        box_flags_q[r.index] = r.flags;
      end
      ModePoint: begin
        has_result = 1'b1;
        return point_hits(r.px, r.py);
      end
      ModeDepth: begin
        has_result = 1'b1;
        return parent_depth(r.id);
      end
      default: ;
    endcase
    return '{default: '0};
  endfunction

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(6, 0);
  endfunction

  // Sends one request. With a zero gap, valid stays high into the next one.
  // A typed-in answer replaces the model's answer in the queue.
  task automatic send_request(request_t r, bit typed, answer_t typed_ans);
    int gap;
    bit has_result;
    answer_t ans;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    drv      <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ans = apply_request(r, has_result);
    if (has_result) pending_answers.push_back(typed ? typed_ans : ans);
    requests_sent++;
  endtask

  // Register writes happen only with nothing in flight.
  task automatic set_entry_count(logic [CountWidth-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_count <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    entry_count_q = value;
  endtask

  function automatic request_t blank_request(logic [ModeWidth-1:0] mode);
    request_t r;
    r = '{default: '0};
    r.mode = mode;
    return r;
  endfunction

  function automatic request_t box_write(int idx, int x, int y, int w, int h, int z,
                                         int id, int parent, int flags);
    request_t r;
    r = blank_request(ModeWrite);
    r.index = IndexWidth'(idx);
    r.bx = coord_t'(x); r.by = coord_t'(y); r.bw = coord_t'(w); r.bh = coord_t'(h);
    r.bz = ZWidth'(z);
    r.id = ident_t'(id); r.parent = ident_t'(parent); r.flags = FlagWidth'(flags);
    return r;
  endfunction

  function automatic request_t point_query(int x, int y);
    request_t r;
    r = blank_request(ModePoint);
    r.px = coord_t'(x); r.py = coord_t'(y);
    return r;
  endfunction

  function automatic request_t depth_query(int id);
    request_t r;
    r = blank_request(ModeDepth);
    r.id = ident_t'(id);
    return r;
  endfunction

  // Random request. Most use a small id pool and a small area so that
  // chains, overlaps and ties are common; the rest is full-range noise.
  function automatic request_t random_request();
    request_t r;
    int pick;
    bit noisy;
    r = '{default: '0};
    r.bx = coord_t'($urandom()); r.by = coord_t'($urandom());
    r.bw = coord_t'($urandom()); r.bh = coord_t'($urandom());
    r.bz = ZWidth'($urandom()); r.px = coord_t'($urandom()); r.py = coord_t'($urandom());
    r.index = IndexWidth'($urandom()); r.flags = FlagWidth'($urandom());
    r.id = ident_t'($urandom()); r.parent = ident_t'($urandom());
    noisy = ($urandom_range(9, 0) < 2);
    pick = $urandom_range(99, 0);
    if (pick < 40) r.mode = ModeWrite;
    else if (pick < 75) r.mode = ModePoint;
    else if (pick < 95) r.mode = ModeDepth;
    else r.mode = ModeNone[ModeWidth-1:0];
    if (!noisy) begin
      r.bx = coord_t'($signed($urandom_range(128, 0)) - 64);
      r.by = coord_t'($signed($urandom_range(128, 0)) - 64);
      r.bw = coord_t'($signed($urandom_range(72, 0)) - 8);
      r.bh = coord_t'($signed($urandom_range(72, 0)) - 8);
      r.bz = ZWidth'($signed($urandom_range(6, 0)) - 3);
      r.px = coord_t'($signed($urandom_range(160, 0)) - 80);
      r.py = coord_t'($signed($urandom_range(160, 0)) - 80);
      r.id = ident_t'($urandom_range(IdPool, 1));
      pick = $urandom_range(9, 0);
      r.parent = (pick < 4) ? '0 : ident_t'($urandom_range(IdPool, 1));
    end
    return r;
  endfunction

  // Result side: random stalls on ready, in-order comparison.
  int stall = 0;
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_answers.size() == 0) begin
        $error("result with no request waiting for one");
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (hit_id !== want.hit_id) begin
          $error("hit_id: expected %0d, got %0d", want.hit_id, hit_id);
          errors++;
        end
        if (hit_bitmap !== want.bitmap) begin
          $error("hit_bitmap: expected %h, got %h", want.bitmap, hit_bitmap);
          errors++;
        end
        if (hit_count !== want.count) begin
          $error("hit_count: expected %0d, got %0d", want.count, hit_count);
          errors++;
        end
        if (depth !== want.depth) begin
          $error("depth: expected %0d, got %0d", want.depth, depth);
          errors++;
        end
        if (depth_found !== want.found) begin
          $error("depth_found: expected %0d, got %0d", want.found, depth_found);
          errors++;
        end
      end
      stall = draw_gap();
    end
    if (stall > 0) begin
      out_ready <= 1'b0;
      stall--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LimitCycles) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  row_t rows[$];
  answer_t none;
  answer_t miss;

  initial begin
    logic [CountWidth-1:0] phase_counts[$];
    int per_phase;

    none = '{default: '0};
    miss = '{default: '0};  // a failed lookup reports all fields zero

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table after reset: nothing is read, nothing can hit.
    send_request(point_query(0, 0), 1'b1, none);
    send_request(depth_query(5), 1'b1, miss);

    // Load every slot with a hidden far-away box so that no query ever reads
    // an unwritten entry.
    calm = 1'b1;
    for (int i = 0; i < TableDepth; i++) begin
      send_request(box_write(i, 28000, 28000, 16, 16, 0, 1000 + i, 0, 0), 1'b0, none);
    end
    calm = 1'b0;
    set_entry_count(CountWidth'(TableDepth));

    // Directed rows. The parent chain is 4 -> 3 -> 2 -> 65535 -> 1 -> root.
    rows.push_back('{box_write(0, -32768, -32768, 32767, 32767, -32768, 1, 0, 3), 0, none});
    rows.push_back('{box_write(1, 0, 0, 16, 16, 32767, 65535, 1, 3), 0, none});
    rows.push_back('{box_write(2, 0, 0, 16, 16, 32767, 2, 65535, 3), 0, none});
    rows.push_back('{box_write(3, 0, 0, -1, 16, 32767, 3, 2, 3), 0, none});
    rows.push_back('{box_write(4, 0, 0, 16, 16, 32767, 4, 3, 1), 0, none});
    rows.push_back('{box_write(5, 0, 0, 16, -32768, 0, 5, 5, 2), 0, none});
    rows.push_back('{box_write(6, -16, -16, 32767, 32767, 0, 6, 7777, 2), 0, none});
    rows.push_back('{point_query(0, 0), 0, none});
    rows.push_back('{point_query(15, 15), 0, none});
    rows.push_back('{point_query(16, 16), 0, none});
    rows.push_back('{point_query(-32768, -32768), 0, none});
    rows.push_back('{point_query(32767, 32767), 0, none});
    rows.push_back('{point_query(-1, 0), 0, none});
    rows.push_back('{depth_query(4), 0, none});
    rows.push_back('{depth_query(1), 0, none});
    rows.push_back('{depth_query(5), 1, miss});      // self-parent cycle
    rows.push_back('{depth_query(6), 1, miss});      // parent not in table
    rows.push_back('{depth_query(0), 1, miss});      // id zero
    rows.push_back('{depth_query(9999), 1, miss});   // id nowhere
    rows.push_back('{blank_request(ModeNone[ModeWidth-1:0]), 0, none});
    rows.push_back('{depth_query(65535), 0, none});
    foreach (rows[k]) send_request(rows[k].req, rows[k].typed, rows[k].ans);

    // Random phases across the count range, clamped values included.
    phase_counts = '{7'd0, 7'd1, 7'd64, 7'd127, 7'd7, 7'd100, 7'd33, 7'd2,
                     7'd65, 7'd64, 7'd12, 7'd48};
    per_phase = 660 / phase_counts.size();
    foreach (phase_counts[p]) begin
      set_entry_count(phase_counts[p]);
      calm = (p % 4 == 3);
      for (int k = 0; k < per_phase; k++) send_request(random_request(), 1'b0, none);
      calm = 1'b0;
    end
    in_valid <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d requests over %0d entry_count settings; checked %0d results.",
             requests_sent, phase_counts.size() + 1, results_seen);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/btht_pkg.sv
sv/box_table_hit_test.sv
verif/tb_box_table_hit_test.sv
